/* rtl/tpie_pkg.sv */
// Shared types and constants of the tape program IR emitter.
package tpie_pkg;

  localparam int SCOPE_DEPTH = 64;
  localparam int INDEX_BITS  = 20;
  localparam int QUEUE_DEPTH = 4;

  localparam int COUNT_W = $clog2(SCOPE_DEPTH + 1);
  localparam int ADDR_W  = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_RIGHT = 8'h3E;
  localparam logic [7:0] SYM_LEFT  = 8'h3C;
  localparam logic [7:0] SYM_IN    = 8'h2C;
  localparam logic [7:0] SYM_OUT   = 8'h2E;
  localparam logic [7:0] SYM_OPEN  = 8'h5B;
  localparam logic [7:0] SYM_CLOSE = 8'h5D;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_MOV    = 3'd1,
    KIND_IN     = 3'd2,
    KIND_OUT    = 3'd3,
    KIND_JMP    = 3'd4,
    KIND_JNZ    = 3'd5,
    KIND_PATCH  = 3'd6,
    KIND_STATUS = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Main instruction of one source byte
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_IN   = 3'd1,
    OP_OUT  = 3'd2,
    OP_JMP  = 3'd3,
    OP_JNZ  = 3'd4
  } op_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] symbol;
    logic       chunk_end;
  } in_word_t;

  typedef struct packed {
    kind_e                  kind;
    logic [INDEX_BITS-1:0]  instr_index;
    logic signed [31:0]     cell_offset;
    logic signed [31:0]     add_delta;
    logic [INDEX_BITS-1:0]  jump_target;
    status_e                status;
    logic                   last;
  } out_word_t;

  // Classified work of one accepted byte, expanded into words by the back end
  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic                  add_en;
    logic signed [31:0]    offset;
    logic signed [31:0]    delta;
    logic                  mov_en;
    op_e                   op;
    logic                  st_en;
    status_e               st_val;
    logic [INDEX_BITS-1:0] pop_idx;
  } rec_t;

endpackage

/* rtl/tpie_front.sv */
// Front end: accepts source words, folds runs, keeps the scope stack, builds records.
module tpie_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tpie_pkg::in_word_t in_word_i,
  input  logic              q_ready_i,
  output logic              q_push_o,
  output tpie_pkg::rec_t    q_rec_o
);

  localparam int IW = tpie_pkg::INDEX_BITS;
  localparam int CW = tpie_pkg::COUNT_W;
  localparam int AW = tpie_pkg::ADDR_W;

  logic [31:0]          tape_offset_q, tape_offset_d;
  logic [31:0]          run_delta_q, run_delta_d;
  logic                 run_open_q, run_open_d;
  logic [CW-1:0]        scope_count_q, scope_count_d;
  logic [IW-1:0]        next_index_q, next_index_d;
  tpie_pkg::status_e    error_q, error_d;

  logic [IW-1:0]        stack_mem [tpie_pkg::SCOPE_DEPTH];
  logic [IW-1:0]        pop_data_q;
  logic                 push_en, pop_en;
  logic [IW-1:0]        push_data;
  logic [CW-1:0]        count_m1;

  tpie_pkg::rec_t       rec, pend_q;
  logic                 pend_valid_q;
  logic                 in_acc, pend_adv, nonempty;

  assign pend_adv   = pend_valid_q && q_ready_i;
  assign in_stall_o = pend_valid_q && !q_ready_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign count_m1   = scope_count_q - CW'(1);

  always_comb begin
    logic fa;
    logic plus;
    fa            = run_open_q && (run_delta_q != 32'd0);
    plus          = (in_word_i.symbol == tpie_pkg::SYM_PLUS);
    tape_offset_d = tape_offset_q;
    run_delta_d   = run_delta_q;
    run_open_d    = run_open_q;
    scope_count_d = scope_count_q;
    error_d       = error_q;
    push_en       = 1'b0;
    pop_en        = 1'b0;
    rec           = '0;
    rec.idx       = next_index_q;
    rec.offset    = tape_offset_q;
    rec.delta     = run_delta_q;
    rec.op        = tpie_pkg::OP_NONE;
    rec.st_val    = tpie_pkg::ST_OK;

    if (in_word_i.mode) begin
      rec.add_en  = fa;
      run_open_d  = 1'b0;
      run_delta_d = 32'd0;
      rec.st_en   = 1'b1;
      if (error_q != tpie_pkg::ST_OK) begin
        rec.st_val = error_q;
      end else if (scope_count_q != '0) begin
        rec.st_val = tpie_pkg::ST_SYNTAX;
      end
    end else begin
      if (error_q == tpie_pkg::ST_OK) begin
        if (plus || in_word_i.symbol == tpie_pkg::SYM_MINUS) begin
          run_open_d  = 1'b1;
          run_delta_d = run_delta_q + (plus ? 32'd1 : 32'hFFFF_FFFF);
        end else begin
          rec.add_en  = fa;
          run_open_d  = 1'b0;
          run_delta_d = 32'd0;
          unique case (in_word_i.symbol)
            tpie_pkg::SYM_RIGHT: tape_offset_d = tape_offset_q + 32'd1;
            tpie_pkg::SYM_LEFT:  tape_offset_d = tape_offset_q - 32'd1;
            tpie_pkg::SYM_IN:    rec.op = tpie_pkg::OP_IN;
            tpie_pkg::SYM_OUT:   rec.op = tpie_pkg::OP_OUT;
            tpie_pkg::SYM_OPEN: begin
              if (scope_count_q == CW'(tpie_pkg::SCOPE_DEPTH)) begin
                error_d   = tpie_pkg::ST_OVERFLOW;
                rec.st_en = 1'b1;
              end else begin
                rec.mov_en    = (tape_offset_q != 32'd0);
                tape_offset_d = 32'd0;
                rec.op        = tpie_pkg::OP_JMP;
                push_en       = 1'b1;
                scope_count_d = scope_count_q + CW'(1);
              end
            end
            tpie_pkg::SYM_CLOSE: begin
              if (scope_count_q == '0) begin
                error_d   = tpie_pkg::ST_SYNTAX;
                rec.st_en = 1'b1;
              end else begin
                rec.mov_en    = (tape_offset_q != 32'd0);
                tape_offset_d = 32'd0;
                rec.op        = tpie_pkg::OP_JNZ;
                pop_en        = 1'b1;
                scope_count_d = count_m1;
              end
            end
            default: ;
          endcase
        end
      end
      // chunk end closes a run that this very byte may have extended
      if (in_word_i.chunk_end) begin
        rec.add_en  = rec.add_en || (run_open_d && (run_delta_d != 32'd0));
        rec.delta   = run_open_d ? run_delta_d : run_delta_q;
        run_open_d  = 1'b0;
        run_delta_d = 32'd0;
        rec.st_en   = 1'b1;
      end
      rec.st_val = error_d;
    end

    push_data    = next_index_q + IW'(rec.add_en) + IW'(rec.mov_en);
    next_index_d = push_data + IW'(rec.op != tpie_pkg::OP_NONE);
    nonempty     = rec.add_en || rec.mov_en || (rec.op != tpie_pkg::OP_NONE) || rec.st_en;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_offset_q <= '0;
      run_delta_q   <= '0;
      run_open_q    <= 1'b0;
      scope_count_q <= '0;
      next_index_q  <= '0;
      error_q       <= tpie_pkg::ST_OK;
      pend_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        tape_offset_q <= tape_offset_d;
        run_delta_q   <= run_delta_d;
        run_open_q    <= run_open_d;
        scope_count_q <= scope_count_d;
        next_index_q  <= next_index_d;
        error_q       <= error_d;
        pend_valid_q  <= nonempty;
      end else if (pend_adv) begin
        pend_valid_q  <= 1'b0;
      end
    end
  end

  // the stack read loads on the same accept as the pending record, so the
  // popped index always belongs to it
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q <= rec;
    end
    if (in_acc && push_en) begin
      stack_mem[scope_count_q[AW-1:0]] <= push_data;
    end
    if (in_acc && pop_en) begin
      pop_data_q <= stack_mem[count_m1[AW-1:0]];
    end
  end

  always_comb begin
    q_rec_o         = pend_q;
    q_rec_o.pop_idx = pop_data_q;
  end

  assign q_push_o = pend_adv;

endmodule

/* rtl/tpie_queue.sv */
// Short record queue between the front and back ends.
module tpie_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tpie_pkg::rec_t push_rec_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tpie_pkg::rec_t pop_rec_o
);

  localparam int PW = tpie_pkg::QPTR_W;
  localparam int CW = tpie_pkg::QCNT_W;
  localparam logic [PW-1:0] LAST_PTR = PW'(tpie_pkg::QUEUE_DEPTH - 1);

  tpie_pkg::rec_t entry_q [tpie_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;

  assign ready_o   = (count_q != CW'(tpie_pkg::QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_rec_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

/* rtl/tpie_back.sv */
// Back end: expands each record into IR words, one per cycle unless the output stalls, into the output register.
module tpie_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  tpie_pkg::rec_t       q_rec_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tpie_pkg::out_word_t  out_word_o
);

  localparam int IW    = tpie_pkg::INDEX_BITS;
  localparam int NSTEP = 5;

  localparam logic [2:0] STEP_ADD    = 3'd0;
  localparam logic [2:0] STEP_MOV    = 3'd1;
  localparam logic [2:0] STEP_OP     = 3'd2;
  localparam logic [2:0] STEP_PATCH  = 3'd3;
  localparam logic [2:0] STEP_STATUS = 3'd4;

  tpie_pkg::rec_t      cur_q;
  logic                cur_valid_q;
  logic [NSTEP-1:0]    rem_q, rem_left, load_mask;
  logic [IW-1:0]       idx_q, idx_next;
  logic                out_valid_q;
  tpie_pkg::out_word_t out_q, word;
  logic [2:0]          sel;
  logic                fire, done, load;

  assign fire    = cur_valid_q && (!out_valid_q || !out_stall_i);
  assign done    = fire && (rem_left == '0);
  assign load    = q_valid_i && (!cur_valid_q || done);
  assign q_pop_o = load;

  assign load_mask = {q_rec_i.st_en, (q_rec_i.op == tpie_pkg::OP_JNZ),
                      (q_rec_i.op != tpie_pkg::OP_NONE), q_rec_i.mov_en, q_rec_i.add_en};

  // take the lowest pending step
  always_comb begin
    sel = STEP_STATUS;
    for (int s = NSTEP - 1; s >= 0; s--) begin
      if (rem_q[s]) begin
        sel = 3'(s);
      end
    end
    rem_left = rem_q & ~(NSTEP'(1) << sel);
  end

  always_comb begin
    logic inc;
    inc              = 1'b0;
    word             = '0;
    word.kind        = tpie_pkg::KIND_STATUS;
    word.status      = tpie_pkg::ST_OK;
    word.instr_index = idx_q;
    unique case (sel)
      STEP_ADD: begin
        word.kind        = tpie_pkg::KIND_ADD;
        word.cell_offset = cur_q.offset;
        word.add_delta   = cur_q.delta;
        inc              = 1'b1;
      end
      STEP_MOV: begin
        word.kind        = tpie_pkg::KIND_MOV;
        word.cell_offset = cur_q.offset;
        inc              = 1'b1;
      end
      STEP_OP: begin
        inc = 1'b1;
        unique case (cur_q.op)
          tpie_pkg::OP_IN: begin
            word.kind        = tpie_pkg::KIND_IN;
            word.cell_offset = cur_q.offset;
          end
          tpie_pkg::OP_OUT: begin
            word.kind        = tpie_pkg::KIND_OUT;
            word.cell_offset = cur_q.offset;
          end
          tpie_pkg::OP_JMP: word.kind = tpie_pkg::KIND_JMP;
          tpie_pkg::OP_JNZ: begin
            word.kind        = tpie_pkg::KIND_JNZ;
            word.jump_target = cur_q.pop_idx + IW'(1);
          end
          default: word.kind = tpie_pkg::KIND_JMP;
        endcase
      end
      STEP_PATCH: begin
        // the JNZ just went out one index below
        word.kind        = tpie_pkg::KIND_PATCH;
        word.instr_index = cur_q.pop_idx;
        word.jump_target = idx_q - IW'(1);
      end
      STEP_STATUS: begin
        word.kind   = tpie_pkg::KIND_STATUS;
        word.status = cur_q.st_val;
      end
      default: ;
    endcase
    word.last = (rem_left == '0);
    idx_next  = idx_q + IW'(inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= 1'b1;
        rem_q       <= load_mask;
      end else if (done) begin
        cur_valid_q <= 1'b0;
        rem_q       <= '0;
      end else if (fire) begin
        rem_q       <= rem_left;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_rec_i;
      idx_q <= q_rec_i.idx;
    end else if (fire) begin
      idx_q <= idx_next;
    end
    if (fire) begin
      out_q <= word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* rtl/tape_program_ir_emitter.sv */
// Top level of the tape program IR emitter: front end, record queue, back end.
// Throughput: one byte per cycle while each gives at most one word and the output is not
// stalled; the back end emits one word per cycle when not stalled, so a closing bracket with
// ADD, MOV and a chunk end gives it five words to emit.
// Reset clears all folding state, counters and queues at once; no clearing pass, as the
// scope stack memory is only read at entries written earlier.
module tape_program_ir_emitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tpie_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tpie_pkg::out_word_t out_word_o
);

  tpie_pkg::rec_t push_rec, pop_rec;
  logic           q_push, q_ready, q_pop, q_valid;

  tpie_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_rec_o    (push_rec)
  );

  tpie_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_rec_i (push_rec),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_rec_o  (pop_rec)
  );

  tpie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (pop_rec),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* rtl/tpie_checker.sv */
// Port-level checks of the tape program IR emitter, bound to the top level.
module tpie_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tpie_pkg::out_word_t out_word_o
);

  logic                            ovf_seen_q;
  logic [tpie_pkg::INDEX_BITS-1:0] jnz_idx_q;
  logic                            out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_seen_q <= 1'b0;
      jnz_idx_q  <= '0;
    end else if (out_acc) begin
      if (out_word_o.kind == tpie_pkg::KIND_STATUS &&
          out_word_o.status == tpie_pkg::ST_OVERFLOW) begin
        ovf_seen_q <= 1'b1;
      end
      if (out_word_o.kind == tpie_pkg::KIND_JNZ) begin
        jnz_idx_q <= out_word_o.instr_index;
      end
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("stalled output word changed");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == tpie_pkg::KIND_STATUS && ovf_seen_q
    |-> out_word_o.status == tpie_pkg::ST_OVERFLOW)
    else $error("overflow status not sticky");

  a_patch_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == tpie_pkg::KIND_PATCH
    |-> out_word_o.jump_target == jnz_idx_q)
    else $error("patch target differs from preceding JNZ index");

  a_jnz_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == tpie_pkg::KIND_JNZ |-> !out_word_o.last)
    else $error("JNZ word closes its byte without a PATCH");

endmodule

bind tape_program_ir_emitter tpie_checker u_tpie_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for the tape program IR emitter: directed table, random programs.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 270;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_MAX   = 10;

  typedef logic [tpie_pkg::INDEX_BITS-1:0] index_t;

  typedef struct {
    tpie_pkg::in_word_t  word;
    bit                  typed;
    tpie_pkg::out_word_t want;
  } script_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  tpie_pkg::in_word_t  in_word   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  tpie_pkg::out_word_t out_word;

  // Side band that travels with the input word: a typed-in expectation
  bit                  note_typed = 1'b0;
  tpie_pkg::out_word_t note_want  = '0;

  int          errors      = 0;
  int          nest_depth  = 0;
  int          sent        = 0;
  bit          in_calm     = 1'b0;
  int unsigned cycle_count = 0;

  // Compiler state mirrored by the predictor
  logic [31:0]       tape_pos    = '0;
  logic [31:0]       run_sum     = '0;
  bit                run_on      = 1'b0;
  int                open_scopes = 0;
  index_t            scope_marks [tpie_pkg::SCOPE_DEPTH];
  index_t            next_idx    = '0;
  tpie_pkg::status_e fault       = tpie_pkg::ST_OK;

  tpie_pkg::out_word_t step_words[$];
  tpie_pkg::out_word_t expected_words[$];

  tape_program_ir_emitter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void emit_word(tpie_pkg::kind_e k, index_t idx, logic [31:0] off,
                                    logic [31:0] delta, index_t tgt,
                                    tpie_pkg::status_e st);
    tpie_pkg::out_word_t w;
    w             = '0;
    w.kind        = k;
    w.instr_index = idx;
    w.cell_offset = off;
    w.add_delta   = delta;
    w.jump_target = tgt;
    w.status      = st;
    step_words.push_back(w);
  endfunction

  function automatic index_t claim_index();
    index_t i;
    i        = next_idx;
    next_idx = next_idx + 1'b1;
    return i;
  endfunction

  function automatic void flush_run();
    if (run_on && run_sum != 0) begin
      emit_word(tpie_pkg::KIND_ADD, claim_index(), tape_pos, run_sum, '0, tpie_pkg::ST_OK);
    end
    run_on  = 1'b0;
    run_sum = '0;
  endfunction

  function automatic void flush_offset();
    if (tape_pos != 0) begin
      emit_word(tpie_pkg::KIND_MOV, claim_index(), tape_pos, '0, '0, tpie_pkg::ST_OK);
      tape_pos = '0;
    end
  endfunction

  // Work out the instructions that one source word produces
  function automatic void compile_word(tpie_pkg::in_word_t w);
    index_t j;
    index_t k;
    bit     want_status;
    want_status = 1'b0;
    if (w.mode) begin
      flush_run();
      emit_word(tpie_pkg::KIND_STATUS, next_idx, '0, '0, '0,
                (fault == tpie_pkg::ST_OK && open_scopes != 0) ? tpie_pkg::ST_SYNTAX : fault);
    end else begin
      if (fault == tpie_pkg::ST_OK) begin
        if (w.symbol == tpie_pkg::SYM_PLUS || w.symbol == tpie_pkg::SYM_MINUS) begin
          run_on  = 1'b1;
          run_sum = (w.symbol == tpie_pkg::SYM_PLUS) ? run_sum + 32'd1 : run_sum - 32'd1;
        end else begin
          flush_run();
          case (w.symbol)
            tpie_pkg::SYM_RIGHT: tape_pos = tape_pos + 32'd1;
            tpie_pkg::SYM_LEFT:  tape_pos = tape_pos - 32'd1;
            tpie_pkg::SYM_IN: begin
              emit_word(tpie_pkg::KIND_IN, claim_index(), tape_pos, '0, '0,
                        tpie_pkg::ST_OK);
            end
            tpie_pkg::SYM_OUT: begin
              emit_word(tpie_pkg::KIND_OUT, claim_index(), tape_pos, '0, '0,
                        tpie_pkg::ST_OK);
            end
            tpie_pkg::SYM_OPEN: begin
              if (open_scopes >= tpie_pkg::SCOPE_DEPTH) begin
                fault       = tpie_pkg::ST_OVERFLOW;
                want_status = 1'b1;
              end else begin
                flush_offset();
                j = claim_index();
                emit_word(tpie_pkg::KIND_JMP, j, '0, '0, '0, tpie_pkg::ST_OK);
                scope_marks[open_scopes] = j;
                open_scopes++;
              end
            end
            tpie_pkg::SYM_CLOSE: begin
              if (open_scopes == 0) begin
                fault       = tpie_pkg::ST_SYNTAX;
                want_status = 1'b1;
              end else begin
                flush_offset();
                k = claim_index();
                open_scopes--;
                j = scope_marks[open_scopes];
                emit_word(tpie_pkg::KIND_JNZ, k, '0, '0, j + 1'b1, tpie_pkg::ST_OK);
                emit_word(tpie_pkg::KIND_PATCH, j, '0, '0, k, tpie_pkg::ST_OK);
              end
            end
            default: ;
          endcase
        end
      end
      if (w.chunk_end) begin
        flush_run();
        want_status = 1'b1;
      end
      if (want_status) begin
        emit_word(tpie_pkg::KIND_STATUS, next_idx, '0, '0, '0, fault);
      end
    end
  endfunction

  function automatic script_row_t row(bit mode, logic [7:0] sym, bit ce, bit typed = 1'b0,
                                      tpie_pkg::kind_e k = tpie_pkg::KIND_ADD,
                                      int idx = 0, int off = 0, int delta = 0,
                                      tpie_pkg::status_e st = tpie_pkg::ST_OK);
    script_row_t r;
    r.word.mode             = mode;
    r.word.symbol           = sym;
    r.word.chunk_end        = ce;
    r.typed                 = typed;
    r.want                  = '0;
    r.want.kind             = k;
    r.want.instr_index      = index_t'(idx);
    r.want.cell_offset      = off;
    r.want.add_delta        = delta;
    r.want.status           = st;
    r.want.last             = 1'b1;
    return r;
  endfunction

  task automatic put_word(tpie_pkg::in_word_t w, bit typed, tpie_pkg::out_word_t want);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_word    <= w;
    note_typed <= typed;
    note_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!w.mode) begin
      if (w.symbol == tpie_pkg::SYM_OPEN) begin
        nest_depth++;
      end else if (w.symbol == tpie_pkg::SYM_CLOSE && nest_depth > 0) begin
        nest_depth--;
      end
    end
    sent++;
    if (sent % 40 == 0) in_calm = !in_calm;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    tpie_pkg::out_word_t w;
    tpie_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("unexpected word: kind %0d idx %0d status %0d",
                   out_word.kind, out_word.instr_index, out_word.status);
        end
      end else begin
        want = expected_words.pop_front();
        if (out_word.kind !== want.kind || out_word.instr_index !== want.instr_index ||
            out_word.cell_offset !== want.cell_offset ||
            out_word.add_delta !== want.add_delta ||
            out_word.jump_target !== want.jump_target ||
            out_word.status !== want.status || out_word.last !== want.last) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("mismatch (expected/actual): kind %0d/%0d idx %0d/%0d off %0d/%0d",
                     want.kind, out_word.kind, want.instr_index, out_word.instr_index,
                     want.cell_offset, out_word.cell_offset);
            $display("  delta %0d/%0d target %0d/%0d status %0d/%0d last %0d/%0d",
                     want.add_delta, out_word.add_delta, want.jump_target,
                     out_word.jump_target, want.status, out_word.status,
                     want.last, out_word.last);
          end
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      compile_word(in_word);
      if (note_typed) begin
        expected_words.push_back(note_want);
      end else begin
        foreach (step_words[i]) begin
          w      = step_words[i];
          w.last = (i == step_words.size() - 1);
          expected_words.push_back(w);
        end
      end
      step_words.delete();
    end
  end

  initial begin : receiver
    int hold;
    int taken;
    bit calm;
    calm  = 1'b0;
    taken = 0;
    @(posedge rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 11);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 50 == 0) calm = !calm;
    end
  end

  initial begin : stimulus
    script_row_t        script[$];
    tpie_pkg::in_word_t w;
    int                 counted;
    int                 r;
    bit                 pick_overflow;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    //                   mode  symbol              end   typed expectation
    script.push_back(row(1'b1, 8'hFF,              1'b1, 1'b1, tpie_pkg::KIND_STATUS, 0, 0, 0));
    script.push_back(row(1'b0, tpie_pkg::SYM_IN,    1'b0, 1'b1, tpie_pkg::KIND_IN, 0, 0));
    script.push_back(row(1'b0, tpie_pkg::SYM_OUT,   1'b0, 1'b1, tpie_pkg::KIND_OUT, 1, 0));
    script.push_back(row(1'b0, tpie_pkg::SYM_PLUS,  1'b0));
    script.push_back(row(1'b0, tpie_pkg::SYM_PLUS,  1'b0));
    script.push_back(row(1'b0, tpie_pkg::SYM_MINUS, 1'b0));
    script.push_back(row(1'b0, tpie_pkg::SYM_RIGHT, 1'b0, 1'b1, tpie_pkg::KIND_ADD, 2, 0, 1));
    script.push_back(row(1'b0, tpie_pkg::SYM_OUT,   1'b0, 1'b1, tpie_pkg::KIND_OUT, 3, 1));
    script.push_back(row(1'b0, tpie_pkg::SYM_MINUS, 1'b1));
    script.push_back(row(1'b0, tpie_pkg::SYM_PLUS,  1'b0));
    script.push_back(row(1'b0, tpie_pkg::SYM_MINUS, 1'b0));
    script.push_back(row(1'b0, 8'h61,              1'b0));   // run folds to zero: no ADD
    script.push_back(row(1'b0, tpie_pkg::SYM_LEFT,  1'b0));
    script.push_back(row(1'b0, tpie_pkg::SYM_LEFT,  1'b0));
    script.push_back(row(1'b0, tpie_pkg::SYM_OPEN,  1'b0));   // MOV, then JMP
    script.push_back(row(1'b0, tpie_pkg::SYM_PLUS,  1'b0));
    script.push_back(row(1'b0, tpie_pkg::SYM_OPEN,  1'b0));   // ADD, then JMP
    script.push_back(row(1'b0, tpie_pkg::SYM_CLOSE, 1'b0));
    script.push_back(row(1'b1, 8'h00,              1'b0));   // finish with a scope still open
    script.push_back(row(1'b0, tpie_pkg::SYM_RIGHT, 1'b0));
    script.push_back(row(1'b0, tpie_pkg::SYM_PLUS,  1'b0));
    script.push_back(row(1'b0, tpie_pkg::SYM_CLOSE, 1'b1));   // ADD, MOV, JNZ, PATCH, STATUS
    script.push_back(row(1'b0, 8'hFF,              1'b0));
    script.push_back(row(1'b0, 8'h00,              1'b1));
    script.push_back(row(1'b1, 8'h5A,              1'b1));
    foreach (script[i]) put_word(script[i].word, script[i].typed, script[i].want);

    counted = 0;
    while (counted < RANDOM_WORDS) begin
      w = '0;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        w.mode      = 1'b1;
        w.symbol    = 8'($urandom_range(0, 255));
        w.chunk_end = 1'($urandom_range(0, 1));
      end else begin
        if (r < 25)      w.symbol = tpie_pkg::SYM_PLUS;
        else if (r < 38) w.symbol = tpie_pkg::SYM_MINUS;
        else if (r < 48) w.symbol = tpie_pkg::SYM_RIGHT;
        else if (r < 56) w.symbol = tpie_pkg::SYM_LEFT;
        else if (r < 62) w.symbol = tpie_pkg::SYM_IN;
        else if (r < 68) w.symbol = tpie_pkg::SYM_OUT;
        else if (r < 79) w.symbol = tpie_pkg::SYM_OPEN;
        else if (r < 90) w.symbol = tpie_pkg::SYM_CLOSE;
        else             w.symbol = 8'($urandom_range(0, 255));
        // nest deeper for a stretch
        if (counted >= 120 && counted < 200 && w.symbol == tpie_pkg::SYM_CLOSE) begin
          w.symbol = tpie_pkg::SYM_OPEN;
        end
        // keep the program legal: no close at depth zero, no open on a full stack
        if (w.symbol == tpie_pkg::SYM_CLOSE && nest_depth == 0) begin
          w.symbol = tpie_pkg::SYM_OPEN;
        end else if (w.symbol == tpie_pkg::SYM_OPEN && nest_depth >= tpie_pkg::SCOPE_DEPTH) begin
          w.symbol = tpie_pkg::SYM_CLOSE;
        end
        w.chunk_end = ($urandom_range(0, 7) == 0);
      end
      if (w.mode || w.chunk_end ||
          w.symbol inside {tpie_pkg::SYM_PLUS, tpie_pkg::SYM_MINUS, tpie_pkg::SYM_RIGHT,
                           tpie_pkg::SYM_LEFT, tpie_pkg::SYM_IN, tpie_pkg::SYM_OUT,
                           tpie_pkg::SYM_OPEN, tpie_pkg::SYM_CLOSE}) begin
        counted++;
      end
      put_word(w, 1'b0, '0);
    end

    // The error is sticky, so the run ends on either overflow or an unmatched close
    pick_overflow = 1'($urandom_range(0, 1));
    w = '0;
    if (pick_overflow) begin
      w.symbol = tpie_pkg::SYM_OPEN;
      while (nest_depth < tpie_pkg::SCOPE_DEPTH) put_word(w, 1'b0, '0);
    end else begin
      w.symbol = tpie_pkg::SYM_CLOSE;
      while (nest_depth > 0) put_word(w, 1'b0, '0);
    end
    w.chunk_end = 1'b1;
    put_word(w, 1'b0, '0);

    repeat (12) begin
      w           = '0;
      w.mode      = ($urandom_range(0, 3) == 0);
      w.symbol    = ($urandom_range(0, 1) == 0) ? tpie_pkg::SYM_OPEN
                                                : 8'($urandom_range(0, 255));
      w.chunk_end = 1'($urandom_range(0, 1));
      put_word(w, 1'b0, '0);
    end
    w      = '0;
    w.mode = 1'b1;
    put_word(w, 1'b0, '0);
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tpie_pkg.sv
rtl/tpie_front.sv
rtl/tpie_queue.sv
rtl/tpie_back.sv
rtl/tape_program_ir_emitter.sv
rtl/tpie_checker.sv
dv/testbench.sv
